### rtl/tcr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and trig table for the triangle centroid rotator.
// No dependencies; imported by every rtl module of the block.
package tcr_pkg;

  localparam int ANGLE_W   = 9;
  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int QSIN_W    = 17;
  localparam int QIDX_W    = 7;
  localparam int X_OUT_W   = 14;
  localparam int Y_OUT_W   = 12;
  localparam int NUM_LANES = 3;
  localparam int OUT_FIELD_W = NUM_LANES * (X_OUT_W + Y_OUT_W);
  localparam int OUT_W     = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [ANGLE_W-1:0] DEG_FULL    = 9'd360;
  localparam logic [ANGLE_W-1:0] DEG_HALF    = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_QUARTER = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_3QUART  = DEG_HALF + DEG_QUARTER;
  localparam logic [QIDX_W-1:0]  QIDX_MAX    = 7'd90;

  localparam int CENTROID_DIV = 3;

  localparam logic [REG_W-1:0] TOOLBAR_RST = 12'd50;
  localparam logic [REG_W-1:0] WINDOW_RST  = 12'd650;
  localparam logic [REG_W-1:0] STATUS_RST  = 12'd50;
  localparam logic [X_OUT_W-1:0] X_OUT_MAX = 14'h3FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOOLBAR = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_STATUS  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] toolbar_height;
    logic [REG_W-1:0] window_height;
    logic [REG_W-1:0] status_bar_height;
  } cfg_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctl_t;

  typedef struct packed {
    logic              neg;
    logic [QIDX_W-1:0] idx;
  } trig_idx_t;

  localparam logic [QSIN_W-1:0] QSIN [0:90] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  function automatic logic [QSIN_W-1:0] quarter_sine(input logic [QIDX_W-1:0] idx);
    logic [QSIN_W-1:0] v;
    if (idx > QIDX_MAX) v = '0;
    else v = QSIN[idx];
    return v;
  endfunction

  // Map an angle in 0..359 degrees to a quarter-wave index and sign.
  function automatic trig_idx_t trig_map(input logic [ANGLE_W-1:0] d);
    trig_idx_t t;
    logic [ANGLE_W-1:0] i;
    if (d <= DEG_QUARTER) begin
      i = d;
      t.neg = 1'b0;
    end else if (d <= DEG_HALF) begin
      i = DEG_HALF - d;
      t.neg = 1'b0;
    end else if (d <= DEG_3QUART) begin
      i = d - DEG_HALF;
      t.neg = 1'b1;
    end else begin
      i = DEG_FULL - d;
      t.neg = 1'b1;
    end
    t.idx = i[QIDX_W-1:0];
    return t;
  endfunction

endpackage

### rtl/tcr_front.sv
`timescale 1ns / 1ps
// Front end: angle reduction, coordinate sums, centroid by reciprocal and sin/cos lookup.
// Two pipeline stages; depends on tcr_pkg.
module tcr_front #(
  parameter int COORD_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [tcr_pkg::ANGLE_W-1:0] angle_i,
  input  logic [COORD_BITS-1:0]       px_i [tcr_pkg::NUM_LANES],
  input  logic [COORD_BITS-1:0]       py_i [tcr_pkg::NUM_LANES],
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [COORD_BITS-1:0]       px_o [tcr_pkg::NUM_LANES],
  output logic [COORD_BITS-1:0]       py_o [tcr_pkg::NUM_LANES],
  output logic [COORD_BITS-1:0]       cx_o,
  output logic [COORD_BITS-1:0]       cy_o,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
  import tcr_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int F      = TRIG_FRAC_BITS;
  localparam int SUM_W  = CB + 2;
  localparam int K      = SUM_W + 1;
  localparam int PROD_W = SUM_W + K;
  localparam int RECIP  = (2 ** K + 2) / CENTROID_DIV;
  localparam logic [K-1:0] RECIP_C = K'(RECIP);
  localparam int UP     = (F >= 16) ? F - 16 : 0;
  localparam int DN     = (F < 16) ? 16 - F : 1;
  localparam int WIDE_W = 26;

  function automatic logic [F:0] scale_mag(input logic [QSIN_W-1:0] q);
    logic [WIDE_W-1:0] w;
    if (F >= 16) w = WIDE_W'(q) << UP;
    else w = (WIDE_W'(q) + (WIDE_W'(1) << (DN - 1))) >> DN;
    return w[F:0];
  endfunction

  logic                 v1_q, v2_q, rdy1, rdy2;
  logic [ANGLE_W-1:0]   a_red, rot_d, rot_q, cos_arg;
  logic [SUM_W-1:0]     sx_d, sy_d, sx_q, sy_q;
  logic [CB-1:0]        px1_q [NUM_LANES];
  logic [CB-1:0]        py1_q [NUM_LANES];
  logic [CB-1:0]        px2_q [NUM_LANES];
  logic [CB-1:0]        py2_q [NUM_LANES];
  logic [PROD_W-1:0]    prod_x, prod_y;
  logic [CB-1:0]        cx_d, cy_d, cx_q, cy_q;
  trig_idx_t            sin_t, cos_t;
  logic [F:0]           sin_mag, cos_mag;
  logic signed [F+1:0]  sin_d, cos_d, sin_q, cos_q;

  assign rdy2      = !v2_q || ready_i;
  assign rdy1      = !v1_q || rdy2;
  assign s_ready_o = rdy1;

  always_comb begin
    a_red = (angle_i >= DEG_FULL) ? angle_i - DEG_FULL : angle_i;
    rot_d = (a_red == '0) ? '0 : DEG_FULL - a_red;
    sx_d  = SUM_W'(px_i[0]) + SUM_W'(px_i[1]) + SUM_W'(px_i[2]);
    sy_d  = SUM_W'(py_i[0]) + SUM_W'(py_i[1]) + SUM_W'(py_i[2]);
  end

  always_comb begin
    cos_arg = (rot_q >= DEG_3QUART) ? rot_q - DEG_3QUART : rot_q + DEG_QUARTER;
    sin_t   = trig_map(rot_q);
    cos_t   = trig_map(cos_arg);
    sin_mag = scale_mag(quarter_sine(sin_t.idx));
    cos_mag = scale_mag(quarter_sine(cos_t.idx));
    sin_d   = sin_t.neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    cos_d   = cos_t.neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    prod_x  = {{K{1'b0}}, sx_q} * {{SUM_W{1'b0}}, RECIP_C};
    prod_y  = {{K{1'b0}}, sy_q} * {{SUM_W{1'b0}}, RECIP_C};
    cx_d    = prod_x[K +: CB];
    cy_d    = prod_y[K +: CB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      rot_q <= rot_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      px1_q <= px_i;
      py1_q <= py_i;
    end
    if (rdy2) begin
      px2_q <= px1_q;
      py2_q <= py1_q;
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign valid_o = v2_q;
  assign px_o    = px2_q;
  assign py_o    = py2_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !ready_i |=> v2_q)
    else $error("front stage 2 dropped a stalled request");
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_ready_o)
    else $error("front refused a request while stage 1 empty");

endmodule

### rtl/tcr_lane.sv
`timescale 1ns / 1ps
// One rotation lane: corner offset, four products, sums and truncation toward zero.
// Two pipeline stages stepped by the top level; depends on tcr_pkg.
module tcr_lane #(
  parameter int COORD_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  tcr_pkg::lane_ctl_t               ctl_i,
  input  logic [COORD_BITS-1:0]            px_i,
  input  logic [COORD_BITS-1:0]            py_i,
  input  logic [COORD_BITS-1:0]            cx_i,
  input  logic [COORD_BITS-1:0]            cy_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_i,
  output logic [COORD_BITS-1:0]            px_o,
  output logic [COORD_BITS-1:0]            py_o,
  output logic signed [COORD_BITS+3:0]     nx_o,
  output logic signed [COORD_BITS+3:0]     ny_o
);
  import tcr_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int F   = TRIG_FRAC_BITS;
  localparam int P_W = CB + F + 3;
  localparam int N_W = P_W + 1;
  localparam int R_W = N_W - F;

  function automatic logic signed [R_W-1:0] trunc_div(input logic signed [N_W-1:0] n);
    logic [N_W-1:0] mag;
    logic [R_W-1:0] q;
    mag = n[N_W-1] ? -n : n;
    q   = mag[N_W-1:F];
    return n[N_W-1] ? -$signed(q) : $signed(q);
  endfunction

  logic signed [CB:0]    dx, dy;
  logic signed [P_W-1:0] dxc_q, dys_q, dxs_q, dyc_q;
  logic [CB-1:0]         px3_q, py3_q, cx3_q, cy3_q, px4_q, py4_q;
  logic signed [N_W-1:0] sum_x, sum_y;
  logic signed [R_W-1:0] nx_d, ny_d, nx_q, ny_q;

  assign dx = $signed({1'b0, px_i}) - $signed({1'b0, cx_i});
  assign dy = $signed({1'b0, py_i}) - $signed({1'b0, cy_i});

  always_comb begin
    sum_x = N_W'(dxc_q) - N_W'(dys_q) + (N_W'($signed({1'b0, cx3_q})) <<< F);
    sum_y = N_W'(dxs_q) + N_W'(dyc_q) + (N_W'($signed({1'b0, cy3_q})) <<< F);
    nx_d  = trunc_div(sum_x);
    ny_d  = trunc_div(sum_y);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_mul) begin
      dxc_q <= P_W'(dx) * P_W'(cos_i);
      dys_q <= P_W'(dy) * P_W'(sin_i);
      dxs_q <= P_W'(dx) * P_W'(sin_i);
      dyc_q <= P_W'(dy) * P_W'(cos_i);
      px3_q <= px_i;
      py3_q <= py_i;
      cx3_q <= cx_i;
      cy3_q <= cy_i;
    end
    if (ctl_i.en_sum) begin
      nx_q  <= nx_d;
      ny_q  <= ny_d;
      px4_q <= px3_q;
      py4_q <= py3_q;
    end
  end

  assign px_o = px4_q;
  assign py_o = py4_q;
  assign nx_o = nx_q;
  assign ny_o = ny_q;

endmodule

### rtl/tcr_merge.sv
`timescale 1ns / 1ps
// Merge stage: window checks on every lane, accept or fall back, output register.
// Depends on tcr_pkg.
module tcr_merge #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcr_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [COORD_BITS-1:0]         px_i [tcr_pkg::NUM_LANES],
  input  logic [COORD_BITS-1:0]         py_i [tcr_pkg::NUM_LANES],
  input  logic signed [COORD_BITS+3:0]  nx_i [tcr_pkg::NUM_LANES],
  input  logic signed [COORD_BITS+3:0]  ny_i [tcr_pkg::NUM_LANES],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcr_pkg::OUT_W-1:0]     out_data_o,
  output logic                          out_ok_o
);
  import tcr_pkg::*;

  localparam int R_W   = COORD_BITS + 4;
  localparam int CMP_W = ((R_W > X_OUT_W) ? R_W : X_OUT_W) + 1;

  logic signed [CMP_W-1:0]  top, bottom, xmax, nx_c, ny_c;
  logic [NUM_LANES-1:0]     bad;
  logic                     ok_d, ok_q, out_valid_q;
  logic [X_OUT_W-1:0]       rx [NUM_LANES];
  logic [Y_OUT_W-1:0]       ry [NUM_LANES];
  logic [OUT_W-1:0]         data_d, data_q;

  assign ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    top    = CMP_W'($signed({1'b0, cfg_i.toolbar_height}));
    bottom = CMP_W'($signed({1'b0, cfg_i.window_height}))
           - CMP_W'($signed({1'b0, cfg_i.status_bar_height}));
    xmax   = CMP_W'($signed({1'b0, X_OUT_MAX}));
    nx_c   = '0;
    ny_c   = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      nx_c   = CMP_W'(nx_i[k]);
      ny_c   = CMP_W'(ny_i[k]);
      bad[k] = (ny_c <= top) || (ny_c >= bottom) || (nx_c < 0) || (ny_c < 0)
            || (nx_c > xmax);
    end
    ok_d = (bad == '0);
    for (int k = 0; k < NUM_LANES; k++) begin
      rx[k] = ok_d ? X_OUT_W'(nx_i[k]) : X_OUT_W'(px_i[k]);
      ry[k] = ok_d ? Y_OUT_W'(ny_i[k]) : Y_OUT_W'(py_i[k]);
    end
    data_d = OUT_W'({ry[2], rx[2], ry[1], rx[1], ry[0], rx[0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (ready_o) out_valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      ok_q   <= ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = data_q;
  assign out_ok_o    = ok_q;

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> out_valid_q)
    else $error("merge lost a request");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !valid_i |=> !out_valid_q)
    else $error("merge repeated a result");

endmodule

### rtl/triangle_centroid_rotator_top.sv
`timescale 1ns / 1ps
// Top level of the triangle centroid rotator: config registers, front end, three lanes, merge.
// Depends on tcr_pkg, tcr_front, tcr_lane, tcr_merge.
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid/s_axis_tready    angle_deg, c1..c3 x/y
// m_axis    out        m_axis_tvalid/m_axis_tready    r1..r3 x/y, tuser = ok
// cfg       in         cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while m_axis_tready is held high.
// A request passes through five register stages: sums, centroid/trig, products, sums, merge.
// Each stage holds under back-pressure and takes new data when it is empty or moving.
// Reset clears all valid bits and loads the register defaults 50 / 650 / 50.
module triangle_centroid_rotator_top #(
  parameter int COORD_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // angle_deg, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y
  input  logic [((9 + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // r1_x, r1_y, r2_x, r2_y, r3_x, r3_y
  output logic [tcr_pkg::OUT_W-1:0]         m_axis_tdata,
  // ok
  output logic                              m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcr_pkg::REG_W-1:0]         cfg_wdata_i
);
  import tcr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int F  = TRIG_FRAC_BITS;

  cfg_t                 cfg_q;
  logic [CB-1:0]        in_px [NUM_LANES];
  logic [CB-1:0]        in_py [NUM_LANES];
  logic [CB-1:0]        f_px  [NUM_LANES];
  logic [CB-1:0]        f_py  [NUM_LANES];
  logic [CB-1:0]        l_px  [NUM_LANES];
  logic [CB-1:0]        l_py  [NUM_LANES];
  logic signed [CB+3:0] l_nx  [NUM_LANES];
  logic signed [CB+3:0] l_ny  [NUM_LANES];
  logic [CB-1:0]        f_cx, f_cy;
  logic signed [F+1:0]  f_sin, f_cos;
  logic                 f_valid, m_ready, v3_q, v4_q, rdy3, rdy4;
  lane_ctl_t            lane_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.toolbar_height    <= TOOLBAR_RST;
      cfg_q.window_height     <= WINDOW_RST;
      cfg_q.status_bar_height <= STATUS_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_TOOLBAR: cfg_q.toolbar_height    <= cfg_wdata_i;
        REG_WINDOW:  cfg_q.window_height     <= cfg_wdata_i;
        REG_STATUS:  cfg_q.status_bar_height <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_unpack
    assign in_px[k] = s_axis_tdata[ANGLE_W + (2 * k) * CB +: CB];
    assign in_py[k] = s_axis_tdata[ANGLE_W + (2 * k + 1) * CB +: CB];
  end

  tcr_front #(
    .COORD_BITS     (CB),
    .TRIG_FRAC_BITS (F)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .angle_i   (s_axis_tdata[ANGLE_W-1:0]),
    .px_i      (in_px),
    .py_i      (in_py),
    .valid_o   (f_valid),
    .ready_i   (rdy3),
    .px_o      (f_px),
    .py_o      (f_py),
    .cx_o      (f_cx),
    .cy_o      (f_cy),
    .sin_o     (f_sin),
    .cos_o     (f_cos)
  );

  assign rdy4            = !v4_q || m_ready;
  assign rdy3            = !v3_q || rdy4;
  assign lane_ctl.en_mul = rdy3;
  assign lane_ctl.en_sum = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= f_valid;
      if (rdy4) v4_q <= v3_q;
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    tcr_lane #(
      .COORD_BITS     (CB),
      .TRIG_FRAC_BITS (F)
    ) u_lane (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .px_i  (f_px[k]),
      .py_i  (f_py[k]),
      .cx_i  (f_cx),
      .cy_i  (f_cy),
      .sin_i (f_sin),
      .cos_i (f_cos),
      .px_o  (l_px[k]),
      .py_o  (l_py[k]),
      .nx_o  (l_nx[k]),
      .ny_o  (l_ny[k])
    );
  end

  tcr_merge #(
    .COORD_BITS (CB)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (v4_q),
    .ready_o     (m_ready),
    .px_i        (l_px),
    .py_i        (l_py),
    .nx_i        (l_nx),
    .ny_i        (l_ny),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_ok_o    (m_axis_tuser)
  );

  a_stage4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !m_ready |=> v4_q)
    else $error("lane stage 4 dropped a stalled request");
  a_stage3_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rdy4 |=> v4_q)
    else $error("lane stage 3 request did not advance");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for triangle_centroid_rotator_top: rotates triangles through
// the stream ports and checks every result against a predictor held in this file.
// Depends on tcr_pkg and the rtl of the block.
module tb;
  import tcr_pkg::*;

  localparam int IN_W = ((9 + 6 * 12 + 7) / 8) * 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int ROT_FRAC = 16;
  localparam longint X_LIMIT = 16383;

  localparam int SINE_Q16 [0:90] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  typedef struct {
    bit [8:0]  angle;
    bit [11:0] x [3];
    bit [11:0] y [3];
  } tri_req_t;

  typedef struct {
    bit        ok;
    bit [13:0] x [3];
    bit [11:0] y [3];
  } tri_res_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_wdata_i;

  bit [11:0] toolbar_h = 12'd50;
  bit [11:0] window_h  = 12'd650;
  bit [11:0] status_h  = 12'd50;

  tri_res_t rot_q [$];
  int       mismatch_cnt = 0;
  bit       idle_on = 1'b1;
  int       sink_hold = 0;

  triangle_centroid_rotator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic longint sine_deg(int unsigned d);
    int unsigned m;
    longint v;
    m = d % 360;
    if (m <= 90) v = SINE_Q16[m];
    else if (m <= 180) v = SINE_Q16[180 - m];
    else if (m <= 270) v = -longint'(SINE_Q16[m - 180]);
    else v = -longint'(SINE_Q16[360 - m]);
    return v;
  endfunction

  function automatic longint trunc_frac(longint num);
    longint q;
    if (num >= 0) q = num >>> ROT_FRAC;
    else q = -((-num) >>> ROT_FRAC);
    return q;
  endfunction

  function automatic tri_res_t rotate_tri(tri_req_t t);
    tri_res_t res;
    longint px [3];
    longint py [3];
    longint nx [3];
    longint ny [3];
    longint cx, cy, s, c, top, bottom, dx, dy;
    int unsigned a, r;
    bit pass;
    for (int k = 0; k < 3; k++) begin
      px[k] = t.x[k];
      py[k] = t.y[k];
    end
    cx = (px[0] + px[1] + px[2]) / 3;
    cy = (py[0] + py[1] + py[2]) / 3;
    a = t.angle % 360;
    r = (360 - a) % 360;
    s = sine_deg(r);
    c = sine_deg(r + 90);
    top = toolbar_h;
    bottom = longint'(window_h) - longint'(status_h);
    pass = 1'b1;
    for (int k = 0; k < 3; k++) begin
      dx = px[k] - cx;
      dy = py[k] - cy;
      nx[k] = trunc_frac(dx * c - dy * s + (cx <<< ROT_FRAC));
      ny[k] = trunc_frac(dx * s + dy * c + (cy <<< ROT_FRAC));
      if (ny[k] <= top || ny[k] >= bottom || nx[k] < 0 || ny[k] < 0 || nx[k] > X_LIMIT)
        pass = 1'b0;
    end
    res.ok = pass;
    for (int k = 0; k < 3; k++) begin
      res.x[k] = 14'(pass ? nx[k] : px[k]);
      res.y[k] = 12'(pass ? ny[k] : py[k]);
    end
    return res;
  endfunction

  function automatic tri_req_t mk_tri(int a, int x1, int y1, int x2, int y2, int x3, int y3);
    tri_req_t t;
    t.angle = 9'(a);
    t.x[0] = 12'(x1);
    t.y[0] = 12'(y1);
    t.x[1] = 12'(x2);
    t.y[1] = 12'(y2);
    t.x[2] = 12'(x3);
    t.y[2] = 12'(y3);
    return t;
  endfunction

  function automatic int clamp12(int v);
    int r;
    r = v;
    if (r < 0) r = 0;
    if (r > 4095) r = 4095;
    return r;
  endfunction

  // Mostly compact triangles placed inside the current drawing area, some raw noise.
  function automatic tri_req_t make_tri();
    tri_req_t t;
    int lo, hi, span, cy, cx;
    if ($urandom_range(0, 3) == 0) begin
      t.angle = 9'($urandom);
      for (int k = 0; k < 3; k++) begin
        t.x[k] = 12'($urandom);
        t.y[k] = 12'($urandom);
      end
    end else begin
      span = ($urandom_range(0, 3) == 0) ? 300 : int'($urandom_range(2, 60));
      lo = int'(toolbar_h) + 1 + span;
      hi = int'(window_h) - int'(status_h) - 1 - span;
      if (hi < lo) begin
        lo = 0;
        hi = 4095;
      end
      if (hi > 4095) hi = 4095;
      cy = $urandom_range(hi, lo);
      cx = $urandom_range(4095, 0);
      t.angle = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(511, 0))
                                            : 9'($urandom_range(359, 0));
      for (int k = 0; k < 3; k++) begin
        t.x[k] = 12'(clamp12(cx + int'($urandom_range(2 * span, 0)) - span));
        t.y[k] = 12'(clamp12(cy + int'($urandom_range(2 * span, 0)) - span));
      end
    end
    return t;
  endfunction

  task automatic note_mismatch(string fld, int unsigned exp_v, int unsigned act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %s at %0t: expected %0d, actual %0d", fld, $realtime, exp_v, act_v);
  endtask

  // Called at a falling edge; returns at a falling edge with the request still offered.
  task automatic send_tri(tri_req_t t);
    int gap;
    tri_res_t exp_r;
    logic [IN_W-1:0] d;
    gap = idle_on ? int'($urandom_range(0, 15)) : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    d = '0;
    d[8:0] = t.angle;
    for (int k = 0; k < 3; k++) begin
      d[9 + 24 * k +: 12] = t.x[k];
      d[21 + 24 * k +: 12] = t.y[k];
    end
    exp_r = rotate_tri(t);
    s_axis_tdata = d;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    rot_q.push_back(exp_r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (rot_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_TOOLBAR: toolbar_h = val;
      REG_WINDOW:  window_h = val;
      REG_STATUS:  status_h = val;
      default: ;
    endcase
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_tri(make_tri());
    end
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_directed();
    tri_req_t t;
    t = mk_tri(0, 100, 100, 200, 100, 150, 200);
    for (int a = 0; a < 9; a++) begin
      t.angle = (a == 0) ? 9'd0 : (a == 1) ? 9'd90 : (a == 2) ? 9'd180 : (a == 3) ? 9'd270 :
                (a == 4) ? 9'd359 : (a == 5) ? 9'd360 : (a == 6) ? 9'd511 :
                (a == 7) ? 9'd45 : 9'd1;
      send_tri(t);
    end
    send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0));
    send_tri(mk_tri(511, 4095, 4095, 4095, 4095, 4095, 4095));
    send_tri(mk_tri(90, 0, 300, 5, 300, 0, 400));
    send_tri(mk_tri(90, 300, 60, 500, 60, 400, 70));
    send_tri(mk_tri(270, 300, 590, 500, 590, 400, 595));
    send_tri(mk_tri(180, 10, 300, 10, 300, 10, 300));
    send_tri(mk_tri(9'h155, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
    send_tri(mk_tri(9'h0AA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
    send_tri(mk_tri(0, 100, 51, 110, 51, 105, 60));
    send_tri(mk_tri(0, 100, 50, 110, 51, 105, 60));
    send_tri(mk_tri(0, 100, 599, 110, 590, 105, 595));
    send_tri(mk_tri(0, 100, 600, 110, 590, 105, 595));
    drain();
  endtask

  task automatic test_random_default();
    run_random(300);
  endtask

  task automatic test_config_sweep();
    write_reg(REG_TOOLBAR, 12'd0);
    write_reg(REG_WINDOW, 12'd4095);
    write_reg(REG_STATUS, 12'd0);
    send_tri(mk_tri(0, 0, 1, 4095, 4094, 2000, 2000));
    send_tri(mk_tri(0, 0, 0, 4095, 4095, 2000, 2000));
    run_random(250);
    write_reg(REG_TOOLBAR, 12'd4095);
    run_random(40);
    write_reg(REG_TOOLBAR, 12'd10);
    write_reg(REG_WINDOW, 12'd0);
    write_reg(REG_STATUS, 12'd4095);
    run_random(40);
    write_reg(REG_TOOLBAR, 12'd100);
    write_reg(REG_WINDOW, 12'd1000);
    write_reg(REG_STATUS, 12'd200);
    write_reg(REG_SPARE, 12'd0);
    run_random(150);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    sink_hold = 300;
    for (int i = 0; i < 80; i++) send_tri(make_tri());
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int b = 0; b < 8; b++) begin
      for (int i = 0; i < 5; i++) send_tri(make_tri());
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    tri_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rot_q.size() == 0) begin
        note_mismatch("unexpected result", 0, 1);
      end else begin
        want = rot_q.pop_front();
        if (want.ok != m_axis_tuser) note_mismatch("ok", want.ok, m_axis_tuser);
        for (int k = 0; k < 3; k++) begin
          if (want.x[k] != m_axis_tdata[26 * k +: 14])
            note_mismatch($sformatf("r%0d_x", k + 1), want.x[k], m_axis_tdata[26 * k +: 14]);
          if (want.y[k] != m_axis_tdata[26 * k + 14 +: 12])
            note_mismatch($sformatf("r%0d_y", k + 1), want.y[k],
                          m_axis_tdata[26 * k + 14 +: 12]);
        end
      end
    end
  end

  // Result side: random stalls per result, plus a long hold-off on request.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        m_axis_tready = 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end
      stall = idle_on ? int'($urandom_range(0, 15)) : 0;
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL triangle_centroid_rotator_top");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TOOLBAR;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_default();
    test_config_sweep();
    test_backpressure();
    test_drain_pause();
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && rot_q.size() == 0) begin
      $display("PASS triangle_centroid_rotator_top");
    end else begin
      $display("FAIL triangle_centroid_rotator_top");
    end
    $finish;
  end

endmodule

### files.f
rtl/tcr_pkg.sv
rtl/tcr_front.sv
rtl/tcr_lane.sv
rtl/tcr_merge.sv
rtl/triangle_centroid_rotator_top.sv
test/tb.sv
